/* src/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared constants and character mapping functions for the base64url codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

	localparam int BYTE_W  = 8;
	localparam int SIX_W   = 6;
	localparam int ACC_W   = 16;
	localparam int HELD_W  = 3;
	localparam int GROUP_W = 24;
	localparam int CHARS   = 4;
	localparam int BUF_W   = CHARS * BYTE_W;
	localparam int CNT_W   = 3;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [SIX_W-1:0]  sextet_t;

	typedef struct packed {
		logic    valid;
		sextet_t value;
	} dec_t;

	function automatic byte_t enc_char(input sextet_t v);
		byte_t wide;
		byte_t c;
		wide = {2'b00, v};
		if (v < 6'd26) begin
			c = 8'h41 + wide;
		end else if (v < 6'd52) begin
			c = 8'h61 + wide - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + wide - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2D;
		end else begin
			c = 8'h5F;
		end
		return c;
	endfunction

	function automatic dec_t dec_char(input byte_t c);
		dec_t  r;
		byte_t t;
		r = '0;
		t = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			r = '{valid: 1'b1, value: t[SIX_W-1:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
			r = '{valid: 1'b1, value: t[SIX_W-1:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
			r = '{valid: 1'b1, value: t[SIX_W-1:0]};
		end else if (c == 8'h2D || c == 8'h2B) begin
			r = '{valid: 1'b1, value: 6'd62};
		end else if (c == 8'h5F || c == 8'h2F) begin
			r = '{valid: 1'b1, value: 6'd63};
		end
		return r;
	endfunction

endpackage

/* src/b64c_if.sv */
// ----------------------------------------------------------------------------
// b64c_if
// Valid/ready stream channels for the codec input and result items.
// ----------------------------------------------------------------------------
interface b64c_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_value;
	logic       out_last;

	modport source (output valid, output out_value, output out_last, input ready);
	modport sink (input valid, input out_value, input out_last, output ready);
endinterface

/* src/base64url_stream_codec.sv */
// Input transfers are registered in the input stage (byte_s1), and their results are then
// registered into the result buffer. Throughput: one input transfer per cycle while no
// results are pending; results leave one per cycle while out_ch.ready is high, and an item
// waits until at most one result is left, so decoding sustains one character per cycle.
// The single-entry result buffer (up to four characters) sets the output rate.
// Reset: arst_n clears direction (encode), the accumulator, and all valid state.
// ----------------------------------------------------------------------------
// base64url_stream_codec
// Unpadded base64url encoder / dual-alphabet decoder with one result buffer.
// ----------------------------------------------------------------------------
module base64url_stream_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	b64c_in_if.sink     in_ch,
	b64c_out_if.source  out_ch
);
	import b64c_pkg::*;

	logic                 dir_q;
	logic [ACC_W-1:0]     acc_q;
	logic [HELD_W-1:0]    held_q;

	logic                 valid_s1;
	byte_t                byte_s1;
	logic                 last_s1;

	logic [BUF_W-1:0]     buf_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 adv;
	logic                 out_xfer;
	logic [GROUP_W-1:0]   grp;
	logic [ACC_W-1:0]     acc_n;
	logic [HELD_W-1:0]    held_n;
	logic [BUF_W-1:0]     buf_n;
	logic [CNT_W-1:0]     cnt_n;
	dec_t                 dv;
	logic [2*SIX_W-1:0]   acc2;
	byte_t                dbyte;

	assign out_xfer      = cnt_q != '0 && out_ch.ready;
	assign adv           = valid_s1 && (cnt_q == '0 || (cnt_q == CNT_W'(1) && out_ch.ready));
	assign in_ch.ready   = !valid_s1 || adv;

	assign out_ch.valid     = cnt_q != '0;
	assign out_ch.out_value = buf_q[BUF_W-1 -: BYTE_W];
	assign out_ch.out_last  = cnt_q == CNT_W'(1);

	always_comb begin
		grp    = '0;
		acc_n  = acc_q;
		held_n = held_q;
		buf_n  = '0;
		cnt_n  = '0;
		dbyte  = '0;
		dv     = dec_char(byte_s1);
		acc2   = {acc_q[SIX_W-1:0], dv.value};
		if (dir_q == DIR_ENCODE) begin
			if (held_q == HELD_W'(2)) begin
				grp    = {acc_q, byte_s1};
				cnt_n  = CNT_W'(4);
				acc_n  = '0;
				held_n = '0;
			end else if (last_s1) begin
				if (held_q == '0) begin
					grp   = {byte_s1, 16'h0000};
					cnt_n = CNT_W'(2);
				end else begin
					grp   = {acc_q[BYTE_W-1:0], byte_s1, 8'h00};
					cnt_n = CNT_W'(3);
				end
			end else begin
				acc_n  = {acc_q[BYTE_W-1:0], byte_s1};
				held_n = held_q + HELD_W'(1);
			end
			buf_n = {enc_char(grp[23:18]), enc_char(grp[17:12]),
				enc_char(grp[11:6]), enc_char(grp[5:0])};
		end else begin
			if (dv.valid) begin
				unique case (held_q)
					HELD_W'(0): begin
						acc_n  = {10'b0, dv.value};
						held_n = HELD_W'(6);
					end
					HELD_W'(2): begin
						dbyte  = acc2[7:0];
						cnt_n  = CNT_W'(1);
						acc_n  = '0;
						held_n = '0;
					end
					HELD_W'(4): begin
						dbyte  = acc2[9:2];
						cnt_n  = CNT_W'(1);
						acc_n  = {14'b0, acc2[1:0]};
						held_n = HELD_W'(2);
					end
					default: begin
						dbyte  = acc2[11:4];
						cnt_n  = CNT_W'(1);
						acc_n  = {12'b0, acc2[3:0]};
						held_n = HELD_W'(4);
					end
				endcase
			end
			buf_n = {dbyte, 24'h000000};
		end
		if (last_s1) begin
			acc_n  = '0;
			held_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENCODE;
			acc_q  <= '0;
			held_q <= '0;
		end else if (cfg_we) begin
			dir_q  <= cfg_wdata;
			acc_q  <= '0;
			held_q <= '0;
		end else if (adv) begin
			acc_q  <= acc_n;
			held_q <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv) begin
			cnt_q <= cnt_n;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			buf_q <= buf_n;
		end else if (out_xfer) begin
			buf_q <= {buf_q[BUF_W-BYTE_W-1:0], 8'h00};
		end
	end

endmodule

/* src/b64c_checker.sv */
// ----------------------------------------------------------------------------
// b64c_checker
// Port-level assertions for base64url_stream_codec, attached by bind.
// ----------------------------------------------------------------------------
module b64c_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       cfg_wdata,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_value,
	input logic       out_last
);
	import b64c_pkg::*;

	logic dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
		else $error("stalled result changed");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("result group ended without last flag");

	a_decode_single: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q == DIR_DECODE && out_valid |-> out_last)
		else $error("decode produced more than one result per item");

endmodule

bind base64url_stream_codec b64c_checker u_b64c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.out_value),
	.out_last  (out_ch.out_last)
);
